[rtl/core/dpd_pkg.sv]
// shared types, codes and helpers for the debug packet deframer
package dpd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COUNT_W   = 12;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 3;
    localparam logic [COUNT_W-1:0] MAX_LEN_RESET = 12'd795;

    // framing characters
    localparam logic [BYTE_W-1:0] CH_INTERRUPT = 8'h03;
    localparam logic [BYTE_W-1:0] CH_START     = 8'h24;
    localparam logic [BYTE_W-1:0] CH_END       = 8'h23;
    localparam logic [BYTE_W-1:0] CH_RESEND    = 8'h2D;

    // register indexes
    localparam logic [0:0] REG_MAX_PAYLOAD_LEN = 1'b0;

    typedef enum logic [2:0] {
        EV_PAYLOAD   = 3'd0,
        EV_GOOD      = 3'd1,
        EV_BAD       = 3'd2,
        EV_RESEND    = 3'd3,
        EV_INTERRUPT = 3'd4,
        EV_OVERFLOW  = 3'd5
    } event_kind_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_DIGIT1  = 4'b0100,
        PH_DIGIT2  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              valid;
        event_kind_t       kind;
        logic [BYTE_W-1:0] data;
    } dpd_event_t;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_digit_t r;
        r.ok    = 1'b1;
        r.value = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = DIGIT_W'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.value = DIGIT_W'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.value = DIGIT_W'(c - 8'h57);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

[rtl/core/dpd_core.sv]
// framing state machine: classifies each byte, keeps sum, count and checksum digits
module dpd_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         byte_accept,
    input  logic [dpd_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [dpd_pkg::COUNT_W-1:0]  max_payload_len,
    output dpd_pkg::dpd_event_t          event_out
);

    dpd_pkg::phase_t                phase_reg, phase_next;
    logic [dpd_pkg::BYTE_W-1:0]     sum_reg, sum_next;
    logic [dpd_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [dpd_pkg::DIGIT_W-1:0]    first_digit_reg, first_digit_next;
    logic                           digit_error_reg, digit_error_next;
    dpd_pkg::hex_digit_t            digit;

    assign digit = dpd_pkg::hex_decode(rx_byte);

    always_comb begin
        phase_next       = phase_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        first_digit_next = first_digit_reg;
        digit_error_next = digit_error_reg;
        event_out.valid  = 1'b0;
        event_out.kind   = dpd_pkg::EV_PAYLOAD;
        event_out.data   = '0;
        if (byte_accept) begin
            unique case (phase_reg)
                dpd_pkg::PH_IDLE: begin
                    if (rx_byte == dpd_pkg::CH_INTERRUPT) begin
                        event_out.valid = 1'b1;
                        event_out.kind  = dpd_pkg::EV_INTERRUPT;
                    end else if (rx_byte == dpd_pkg::CH_RESEND) begin
                        event_out.valid = 1'b1;
                        event_out.kind  = dpd_pkg::EV_RESEND;
                    end else if (rx_byte == dpd_pkg::CH_START) begin
                        phase_next       = dpd_pkg::PH_PAYLOAD;
                        sum_next         = '0;
                        count_next       = '0;
                        digit_error_next = 1'b0;
                        first_digit_next = '0;
                    end
                end
                dpd_pkg::PH_PAYLOAD: begin
                    if (rx_byte == dpd_pkg::CH_END) begin
                        phase_next = dpd_pkg::PH_DIGIT1;
                    end else if (count_reg >= max_payload_len) begin
                        // packet dropped, rest of it is read as idle bytes
                        phase_next      = dpd_pkg::PH_IDLE;
                        sum_next        = '0;
                        count_next      = '0;
                        event_out.valid = 1'b1;
                        event_out.kind  = dpd_pkg::EV_OVERFLOW;
                    end else begin
                        count_next      = count_reg + 1'b1;
                        sum_next        = sum_reg + rx_byte;
                        event_out.valid = 1'b1;
                        event_out.kind  = dpd_pkg::EV_PAYLOAD;
                        event_out.data  = rx_byte;
                    end
                end
                dpd_pkg::PH_DIGIT1: begin
                    first_digit_next = digit.value;
                    if (!digit.ok) begin
                        digit_error_next = 1'b1;
                    end
                    phase_next = dpd_pkg::PH_DIGIT2;
                end
                dpd_pkg::PH_DIGIT2: begin
                    phase_next       = dpd_pkg::PH_IDLE;
                    digit_error_next = 1'b0;
                    event_out.valid  = 1'b1;
                    if (!digit_error_reg && digit.ok
                        && {first_digit_reg, digit.value} == sum_reg) begin
                        event_out.kind = dpd_pkg::EV_GOOD;
                    end else begin
                        event_out.kind = dpd_pkg::EV_BAD;
                    end
                end
                default: begin
                    phase_next = dpd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= dpd_pkg::PH_IDLE;
            sum_reg         <= '0;
            count_reg       <= '0;
            first_digit_reg <= '0;
            digit_error_reg <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            first_digit_reg <= first_digit_next;
            digit_error_reg <= digit_error_next;
        end
    end

endmodule

[rtl/core/debug_packet_deframer.sv]
// debug packet deframer: takes one byte per cycle while s_tready is high from a remote debug
// link and splits the stream into payload, checksum verdict, resend, interrupt and overflow events.
// Each byte is classified, the modulo-256 sum and byte count are updated and the event is written to
// the output register in the cycle it is accepted. s_tready stays high while the output
// register is empty or being drained, so a byte can be taken every cycle; a byte that raises
// no event (start, end marker, first checksum digit, ignored idle bytes) leaves m_tvalid low.
// The payload limit is set through the APB register at address 0 and should only be changed
// between packets.
module debug_packet_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input byte stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    // event stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [7:0] payload_byte
    output logic [2:0]                     m_tuser,   // [2:0] event_kind
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dpd_pkg::APB_AW-1:0]     paddr,
    input  logic [dpd_pkg::APB_DW-1:0]     pwdata,
    output logic [dpd_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    logic [dpd_pkg::COUNT_W-1:0]  max_len_reg, max_len_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [7:0]                   m_tdata_reg, m_tdata_next;
    logic [2:0]                   m_tuser_reg, m_tuser_next;
    logic                         in_accept;
    logic                         reg_hit;
    dpd_pkg::dpd_event_t          ev;

    assign pready   = 1'b1;
    assign reg_hit  = (paddr[dpd_pkg::APB_AW-1] == dpd_pkg::REG_MAX_PAYLOAD_LEN);
    assign prdata   = reg_hit ? dpd_pkg::APB_DW'(max_len_reg) : '0;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    dpd_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .byte_accept     (in_accept),
        .rx_byte         (s_tdata),
        .max_payload_len (max_len_reg),
        .event_out       (ev)
    );

    always_comb begin
        max_len_next = max_len_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            max_len_next = pwdata[dpd_pkg::COUNT_W-1:0];
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (in_accept) begin
            m_tvalid_next = ev.valid;
            m_tdata_next  = ev.data;
            m_tuser_next  = ev.kind;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg  <= dpd_pkg::MAX_LEN_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            max_len_reg  <= max_len_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
